// ===== sv/bhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// bhsv_pkg
// Types and constants shared by the BGR to HSV pixel converter.
// ----------------------------------------------------------------------------
package bhsv_pkg;

	localparam int unsigned CH_W      = 8;   // channel width
	localparam int unsigned NUM_W     = 16;  // dividend width of both quotients
	localparam int unsigned DIV_STEPS = 8;   // one quotient bit per step

	localparam logic [CH_W-1:0] HUE_WRAP = 8'd180;  // half-degrees in a full turn
	localparam logic [CH_W-1:0] SAT_FULL = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] red_in;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] hue_out;
		logic [CH_W-1:0] sat_out;
		logic [CH_W-1:0] val_out;
	} hsv_t;

	// Classified pixel, ready for the two divisions.
	typedef struct packed {
		logic [NUM_W-1:0] hue_num;
		logic [CH_W-1:0]  hue_den;
		logic [NUM_W-1:0] sat_num;
		logic [CH_W-1:0]  sat_den;
		logic [CH_W-1:0]  vmax;
	} job_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

endpackage

// ===== sv/bhsv_front.sv =====
// ----------------------------------------------------------------------------
// bhsv_front
// Takes a pixel, finds max/min and hue sector, forms both dividends.
// ----------------------------------------------------------------------------
module bhsv_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  bhsv_pkg::pixel_t pixel,
	output logic             job_vld,
	output bhsv_pkg::job_t   job
);

	logic [7:0]          b, g, r;
	logic [7:0]          vmax, vmin, delta;
	bhsv_pkg::sector_t   sector;
	logic signed [8:0]   diff;
	logic signed [17:0]  ofs;
	logic signed [17:0]  num;
	logic signed [17:0]  d18;
	bhsv_pkg::job_t      job_d;

	logic                vld_s1;
	bhsv_pkg::job_t      job_s1;

	always_comb begin
		b = pixel.blue_in;
		g = pixel.green_in;
		r = pixel.red_in;
		vmax = (b > g) ? b : g;
		vmax = (vmax > r) ? vmax : r;
		vmin = (b < g) ? b : g;
		vmin = (vmin < r) ? vmin : r;
		delta = vmax - vmin;

		// ties go red, then green, then blue
		if (vmax == r)
			sector = bhsv_pkg::SEC_RED;
		else if (vmax == g)
			sector = bhsv_pkg::SEC_GREEN;
		else
			sector = bhsv_pkg::SEC_BLUE;

		unique case (sector)
			bhsv_pkg::SEC_RED: begin
				diff = $signed({1'b0, g}) - $signed({1'b0, b});
				ofs  = 18'sd0;
			end
			bhsv_pkg::SEC_GREEN: begin
				diff = $signed({1'b0, b}) - $signed({1'b0, r});
				ofs  = 18'sd60;
			end
			default: begin
				diff = $signed({1'b0, r}) - $signed({1'b0, g});
				ofs  = 18'sd120;
			end
		endcase

		d18 = $signed({10'b0, delta});
		num = ofs * d18 + $signed({{9{diff[8]}}, diff}) * 18'sd30;
		// only the red sector can go negative
		if (num < 0)
			num = num + 18'sd180 * d18;

		job_d.hue_num = num[15:0] + 16'(delta >> 1);
		job_d.hue_den = (delta == 8'd0) ? 8'd1 : delta;
		job_d.sat_num = 16'(delta) * 16'(bhsv_pkg::SAT_FULL) + 16'(vmax >> 1);
		job_d.sat_den = (vmax == 8'd0) ? 8'd1 : vmax;
		job_d.vmax    = vmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept)
			job_s1 <= job_d;
	end

	assign job_vld = vld_s1;
	assign job     = job_s1;

endmodule

// ===== sv/bhsv_queue.sv =====
// ----------------------------------------------------------------------------
// bhsv_queue
// Two-entry queue between classification and division.
// ----------------------------------------------------------------------------
module bhsv_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bhsv_pkg::job_t push_data,
	output logic           full,
	output logic           pop_vld,
	output bhsv_pkg::job_t pop_data
);

	bhsv_pkg::job_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	// back end never stalls, so the head leaves as soon as it is there
	assign pop      = (count_q != 2'd0);
	assign pop_vld  = pop;
	assign pop_data = ent_q[rd_ptr_q];
	assign full     = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == 2'd0) |=> pop_vld)
		else $error("pushed transaction not visible at head");

endmodule

// ===== sv/bhsv_div.sv =====
// ----------------------------------------------------------------------------
// bhsv_div
// Pipelined restoring divider, 16-bit by 8-bit, one quotient bit per stage.
// Quotient must fit 8 bits (num < 256 * den).
// ----------------------------------------------------------------------------
module bhsv_div (
	input  logic        clk,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic [7:0]  quo
);

	localparam int unsigned LAST = bhsv_pkg::DIV_STEPS - 1;

	logic [7:0] rem_s [LAST];
	logic [7:0] low_s [LAST];
	logic [7:0] den_s [LAST];
	logic [7:0] quo_s [bhsv_pkg::DIV_STEPS];

	for (genvar k = 0; k < bhsv_pkg::DIV_STEPS; k++) begin : g_step
		logic [7:0] rem_i, low_i, den_i, quo_i;
		logic [8:0] trial;
		logic       ge;

		if (k == 0) begin : g_first
			assign rem_i = num[15:8];
			assign low_i = num[7:0];
			assign den_i = den;
			assign quo_i = 8'd0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
		end

		assign trial = {rem_i, low_i[7]};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_i[6:0], ge};
		end

		if (k < LAST) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? 8'(trial - {1'b0, den_i}) : trial[7:0];
				low_s[k] <= {low_i[6:0], 1'b0};
				den_s[k] <= den_i;
			end
		end
	end

	assign quo = quo_s[LAST];

endmodule

// ===== sv/bhsv_back.sv =====
// ----------------------------------------------------------------------------
// bhsv_back
// Runs hue and saturation divisions side by side and registers the result.
// ----------------------------------------------------------------------------
module bhsv_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_vld,
	input  bhsv_pkg::job_t job,
	output logic           done,
	output bhsv_pkg::hsv_t result
);

	localparam int unsigned LAST = bhsv_pkg::DIV_STEPS - 1;

	logic           vld_s [bhsv_pkg::DIV_STEPS];
	logic [7:0]     val_s [bhsv_pkg::DIV_STEPS];
	logic [7:0]     hue_quo, sat_quo;
	logic           done_q;
	bhsv_pkg::hsv_t res_q;

	bhsv_div u_hue_div (
		.clk (clk),
		.num (job.hue_num),
		.den (job.hue_den),
		.quo (hue_quo)
	);

	bhsv_div u_sat_div (
		.clk (clk),
		.num (job.sat_num),
		.den (job.sat_den),
		.quo (sat_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bhsv_pkg::DIV_STEPS; i++)
				vld_s[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s[0] <= job_vld;
			for (int i = 1; i < bhsv_pkg::DIV_STEPS; i++)
				vld_s[i] <= vld_s[i-1];
			done_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		val_s[0] <= job.vmax;
		for (int i = 1; i < bhsv_pkg::DIV_STEPS; i++)
			val_s[i] <= val_s[i-1];
		if (vld_s[LAST]) begin
			// rounding can land on a full turn
			res_q.hue_out <= (hue_quo == bhsv_pkg::HUE_WRAP) ? 8'd0 : hue_quo;
			res_q.sat_out <= sat_quo;
			res_q.val_out <= val_s[LAST];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== sv/bgr_to_hsv_pixel.sv =====
// ----------------------------------------------------------------------------
// bgr_to_hsv_pixel
// Converts one 8-bit B,G,R pixel to 8-bit H (half-degrees), S and V.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel and raise start; the transaction is taken at a rising edge
//   where start is high and busy is low. One pixel may be taken every cycle.
//   Each result shows on result for exactly one cycle with done high, and is
//   taken at the edge that ends that cycle; there is no way to hold it off.
// Pipeline: the classify register loads on the accepting edge itself;
//   after it come 1 queue stage, 8 divider stages and 1 output register.
// Throughput: one pixel per clock while busy is low. The hue and saturation
//   quotients come from two pipelined restoring dividers that retire one
//   quotient bit per stage, so they accept a new pair every cycle.
// busy: high only when the queue between the classifier and the dividers is
//   full; the dividers drain it every cycle, so in practice it stays low.
// Reset: arst_n clears all valid state at once; no result is pending after
//   reset and the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module bgr_to_hsv_pixel (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bhsv_pkg::pixel_t pixel,
	output logic             busy,
	output logic             done,
	output bhsv_pkg::hsv_t   result
);

	logic           accept;
	logic           front_vld;
	bhsv_pkg::job_t front_job;
	logic           q_full;
	logic           q_vld;
	bhsv_pkg::job_t q_job;

	assign busy   = q_full;
	assign accept = start && !q_full;

	bhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.pixel   (pixel),
		.job_vld (front_vld),
		.job     (front_job)
	);

	bhsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_vld),
		.push_data (front_job),
		.full      (q_full),
		.pop_vld   (q_vld),
		.pop_data  (q_job)
	);

	bhsv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_vld (q_vld),
		.job     (q_job),
		.done    (done),
		.result  (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##11 done)
		else $error("transaction result missing at expected cycle");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hue_out < bhsv_pkg::HUE_WRAP))
		else $error("hue out of range");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.val_out == 8'd0) |-> (result.sat_out == 8'd0 &&
			result.hue_out == 8'd0))
		else $error("black pixel with nonzero hue or saturation");

endmodule
